### rtl/core/rlsl_pkg.sv
// Package for the run-length smear line core: constants, register indexes,
// configuration and command types shared by the front, queue and back.
// No dependencies.
`timescale 1ns / 1ps

package rlsl_pkg;

    // Default largest smear range, and the width of the range register
    localparam int C_MAX_RANGE = 64;
    localparam int C_RANGE_W   = 7;
    localparam int C_PIX_W     = 8;

    // Pixel codes
    localparam logic [C_PIX_W-1:0] C_PIX_BLACK = 8'd0;
    localparam logic [C_PIX_W-1:0] C_PIX_WHITE = 8'd255;

    // Configuration register indexes
    localparam int C_CFG_IDX_W = 2;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SMEAR_RANGE  = 2'd0;
    localparam logic [C_CFG_IDX_W-1:0] C_REG_SMEAR_ENABLE = 2'd1;

    // Live configuration
    typedef struct packed {
        logic [C_RANGE_W-1:0] smear_range;
        logic                 smear_enable;
    } t_cfg;

    // One command from front to back: flush cnt held whites (as black when
    // fill), then optionally emit one pixel
    typedef struct packed {
        logic [C_RANGE_W-1:0] cnt;
        logic                 fill;
        logic                 has_emit;
        logic [C_PIX_W-1:0]   px;
        logic                 le;
    } t_cmd;

endpackage

### rtl/core/rlsl_front.sv
// Front of the smear core: accepts pixels, tracks the line state, stores
// held whites and issues flush/emit commands. Depends on rlsl_pkg.
`timescale 1ns / 1ps

module rlsl_front
    import rlsl_pkg::*;
#(
    parameter int MAX_RANGE = C_MAX_RANGE,
    parameter int AW        = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [C_PIX_W-1:0] i_pixel_in,
    input  logic               i_line_end,
    input  logic               i_q_full,
    input  logic               i_rd_done,
    output logic               o_push,
    output t_cmd               o_cmd,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_wr_addr,
    output logic [C_PIX_W-1:0] o_wr_data
);

    localparam logic [C_RANGE_W-1:0] MAXR = C_RANGE_W'(MAX_RANGE);

    logic [AW-1:0]        r_held;
    logic [AW-1:0]        n_held;
    logic                 r_black;
    logic                 n_black;
    logic                 r_gap;
    logic                 n_gap;
    logic                 r_busy;
    logic                 n_busy;
    logic                 accept;
    logic                 held_case;
    logic [C_RANGE_W-1:0] rng;
    logic [C_RANGE_W-1:0] hc;
    logic [C_RANGE_W-1:0] hc_p1;
    t_cmd                 cmd;

    // Stall while the queue is full or stored whites are being replayed
    assign o_in_stall = i_q_full || r_busy;
    assign accept     = i_in_valid && !o_in_stall;

    assign rng   = (i_cfg.smear_range > MAXR) ? MAXR : i_cfg.smear_range;
    assign hc    = C_RANGE_W'(r_held);
    assign hc_p1 = hc + C_RANGE_W'(1);

    // Classify the pixel and build its command
    always_comb begin
        cmd       = '0;
        n_held    = r_held;
        n_black   = r_black;
        n_gap     = r_gap;
        held_case = 1'b0;
        o_wr_en   = 1'b0;
        if (accept) begin
            cmd.le = i_line_end;
            if (!i_cfg.smear_enable) begin
                cmd.cnt      = hc;
                cmd.has_emit = 1'b1;
                cmd.px       = i_pixel_in;
                n_held       = '0;
                n_black      = 1'b0;
                n_gap        = 1'b0;
            end else begin
                priority if (!r_black) begin
                    cmd.has_emit = 1'b1;
                    if (i_pixel_in == C_PIX_BLACK) begin
                        cmd.px  = C_PIX_BLACK;
                        n_black = 1'b1;
                    end else begin
                        cmd.px = C_PIX_WHITE;
                    end
                end else if (i_pixel_in == C_PIX_BLACK) begin
                    cmd.cnt      = hc;
                    cmd.fill     = (hc < rng);
                    cmd.has_emit = 1'b1;
                    cmd.px       = C_PIX_BLACK;
                    n_held       = '0;
                    n_gap        = 1'b0;
                end else if (r_gap) begin
                    cmd.has_emit = 1'b1;
                    cmd.px       = i_pixel_in;
                end else if (hc_p1 >= rng) begin
                    cmd.cnt      = hc;
                    cmd.has_emit = 1'b1;
                    cmd.px       = i_pixel_in;
                    n_held       = '0;
                    n_gap        = 1'b1;
                end else begin
                    o_wr_en   = 1'b1;
                    held_case = 1'b1;
                    n_held    = r_held + AW'(1);
                end
                // Line end: replay everything held, including this pixel
                if (i_line_end) begin
                    if (held_case) begin
                        cmd.cnt  = hc_p1;
                        cmd.fill = 1'b0;
                    end
                    n_held  = '0;
                    n_black = 1'b0;
                    n_gap   = 1'b0;
                end
            end
        end
    end

    assign o_push    = accept && (cmd.has_emit || (cmd.cnt != '0));
    assign o_cmd     = cmd;
    assign o_wr_addr = r_held;
    assign o_wr_data = i_pixel_in;

    // Track a replay of stored whites that is still outstanding
    always_comb begin
        n_busy = r_busy;
        if (i_rd_done) begin
            n_busy = 1'b0;
        end
        if (o_push && (cmd.cnt != '0) && !cmd.fill) begin
            n_busy = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_black <= 1'b0;
            r_gap   <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_held  <= n_held;
            r_black <= n_black;
            r_gap   <= n_gap;
            r_busy  <= n_busy;
        end
    end

endmodule

### rtl/core/rlsl_cmd_fifo.sv
// Two-entry command queue between front and back of the smear core.
// Depends on rlsl_pkg.
`timescale 1ns / 1ps

module rlsl_cmd_fifo
    import rlsl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_data,
    input  logic i_pop
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_slot[r_rp];

    // Store a pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

### rtl/core/rlsl_back.sv
// Back of the smear core: holds the white store, replays flushes and
// emits results through an output register. Depends on rlsl_pkg.
`timescale 1ns / 1ps

module rlsl_back
    import rlsl_pkg::*;
#(
    parameter int MAX_RANGE = C_MAX_RANGE,
    parameter int AW        = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [AW-1:0]      i_wr_addr,
    input  logic [C_PIX_W-1:0] i_wr_data,
    input  logic               i_q_valid,
    input  t_cmd               i_q_data,
    output logic               o_pop,
    output logic               o_rd_done,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [C_PIX_W-1:0] o_pixel_out,
    output logic               o_last_of_run,
    output logic               o_line_done
);

    logic [C_PIX_W-1:0]   mem [MAX_RANGE];
    logic [C_PIX_W-1:0]   r_rd_data;
    logic                 r_rd_ok;
    logic [C_RANGE_W-1:0] r_idx;
    logic [C_RANGE_W-1:0] n_idx;
    logic                 r_o_valid;
    logic [C_PIX_W-1:0]   r_o_pixel;
    logic                 r_o_last;
    logic                 r_o_line;
    logic                 ld_ok;
    logic                 in_flush;
    logic                 flush_last;
    logic                 produce;
    logic [C_PIX_W-1:0]   px;
    logic                 last;

    assign ld_ok      = !r_o_valid || !i_out_stall;
    assign in_flush   = (r_idx < i_q_data.cnt);
    assign flush_last = (r_idx == (i_q_data.cnt - C_RANGE_W'(1)));

    // Pick the next result of the head command
    always_comb begin
        produce = 1'b0;
        px      = i_q_data.px;
        last    = 1'b1;
        o_pop   = 1'b0;
        n_idx   = r_idx;
        if (i_q_valid && ld_ok) begin
            if (in_flush) begin
                produce = i_q_data.fill || r_rd_ok;
                px      = i_q_data.fill ? C_PIX_BLACK : r_rd_data;
                last    = flush_last && !i_q_data.has_emit;
            end else begin
                produce = i_q_data.has_emit;
            end
            // Advance past the flushed entry, rewind when the command retires
            if (produce) begin
                o_pop = last || !in_flush;
                n_idx = o_pop ? '0 : (r_idx + C_RANGE_W'(1));
            end
        end
    end

    assign o_rd_done = o_pop && (i_q_data.cnt != '0) && !i_q_data.fill;

    // White store: one write port, registered read at the next index
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[n_idx[AW-1:0]];
    end

    // Hold replay index and read-data validity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_rd_ok <= !i_wr_en;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (ld_ok) begin
            r_o_valid <= produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_ok && produce) begin
            r_o_pixel <= px;
            r_o_last  <= last;
            r_o_line  <= last && i_q_data.le;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_pixel_out   = r_o_pixel;
    assign o_last_of_run = r_o_last;
    assign o_line_done   = r_o_line;

endmodule

### rtl/core/run_length_smear_line_core.sv
// Run-length smear line core. Pixels of one line enter one per cycle on
// the input channel (0 is black) while it is not stalled; each produces
// zero or more smeared pixels in line order on the output channel, one
// result per cycle while the output is not stalled. A white inside a gap
// after a black is stored and produces no output yet; the closing black, a
// gap that grows too long, a disabled pass or the line end releases the
// stored whites. The front takes a pixel each cycle unless its two-entry
// command queue is full, or while stored whites are being read back from
// the white store (one entry per cycle through its registered read port
// while the output is not stalled, waiting when a white was stored on the
// cycle before); filled gaps need no read-back. The store needs no
// clearing pass after reset. Depends on rlsl_pkg, rlsl_front,
// rlsl_cmd_fifo and rlsl_back.
`timescale 1ns / 1ps

module run_length_smear_line_core
    import rlsl_pkg::*;
#(
    parameter int MAX_RANGE = C_MAX_RANGE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [C_RANGE_W-1:0]   i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [C_PIX_W-1:0]     i_pixel_in,
    input  logic                   i_line_end,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [C_PIX_W-1:0]     o_pixel_out,
    output logic                   o_last_of_run,
    output logic                   o_line_done
);

    localparam int AW = (MAX_RANGE > 1) ? $clog2(MAX_RANGE) : 1;

    t_cfg               r_cfg;
    logic               q_full;
    logic               q_valid;
    logic               push;
    logic               pop;
    logic               rd_done;
    t_cmd               cmd;
    t_cmd               head;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [C_PIX_W-1:0] wr_data;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smear_range  <= '0;
            r_cfg.smear_enable <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == C_REG_SMEAR_RANGE) begin
                r_cfg.smear_range <= i_cfg_data;
            end else if (i_cfg_idx == C_REG_SMEAR_ENABLE) begin
                r_cfg.smear_enable <= i_cfg_data[0];
            end
        end
    end

    rlsl_front #(
        .MAX_RANGE(MAX_RANGE),
        .AW       (AW)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_pixel_in(i_pixel_in),
        .i_line_end(i_line_end),
        .i_q_full  (q_full),
        .i_rd_done (rd_done),
        .o_push    (push),
        .o_cmd     (cmd),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data)
    );

    rlsl_cmd_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (cmd),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (head),
        .i_pop  (pop)
    );

    rlsl_back #(
        .MAX_RANGE(MAX_RANGE),
        .AW       (AW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (wr_en),
        .i_wr_addr    (wr_addr),
        .i_wr_data    (wr_data),
        .i_q_valid    (q_valid),
        .i_q_data     (head),
        .o_pop        (pop),
        .o_rd_done    (rd_done),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_last_of_run(o_last_of_run),
        .o_line_done  (o_line_done)
    );

endmodule

### rtl/core/rlsl_checker.sv
// Port-level checks for the run-length smear line core, bound to the top.
// Depends on rlsl_pkg and run_length_smear_line_core.
`timescale 1ns / 1ps

module rlsl_checker
    import rlsl_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [C_PIX_W-1:0] o_pixel_out,
    input logic               o_last_of_run,
    input logic               o_line_done
);

    // Leave reset with no result pending and the input open
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("core not quiet after reset");

    // A line closes only on the last result of its pixel
    a_line_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_done |-> o_last_of_run)
        else $error("line_done without last_of_run");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_out)
            && $stable(o_last_of_run) && $stable(o_line_done))
        else $error("stalled result changed");

endmodule

bind run_length_smear_line_core rlsl_checker u_rlsl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_pixel_out  (o_pixel_out),
    .o_last_of_run(o_last_of_run),
    .o_line_done  (o_line_done)
);

### tb/testbench.sv
// Testbench for run_length_smear_line_core: drives pixel lines with random idling,
// predicts the smeared pixel stream and checks every result in order.
// Depends on rlsl_pkg and run_length_smear_line_core.
`timescale 1ns / 1ps

module testbench;
    import rlsl_pkg::*;

    // Spare register indexes; writes to them must leave the block unchanged
    localparam logic [C_CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [C_CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 16;

    typedef struct {
        logic [C_PIX_W-1:0] px;
        logic               last;
        logic               done;
    } smear_result_t;

    // Predicts the smeared pixels of each accepted request and checks outputs
    class smear_checker;
        logic [C_PIX_W-1:0]   held_px [C_MAX_RANGE];
        int unsigned          held_n;
        bit                   black_seen;
        bit                   gap_open;
        logic [C_RANGE_W-1:0] range_reg;
        bit                   enable_reg;
        smear_result_t        step_q[$];
        smear_result_t        pending_pixels[$];
        int                   errors;

        function new();
            held_n     = 0;
            black_seen = 0;
            gap_open   = 0;
            range_reg  = '0;
            enable_reg = 1'b1;
            errors     = 0;
        endfunction

        function void set_reg(logic [C_CFG_IDX_W-1:0] idx, logic [C_RANGE_W-1:0] val);
            if (idx == C_REG_SMEAR_RANGE) begin
                range_reg = val;
            end else if (idx == C_REG_SMEAR_ENABLE) begin
                enable_reg = val[0];
            end
        endfunction

        function void emit_px(logic [C_PIX_W-1:0] px);
            smear_result_t res;
            res.px   = px;
            res.last = 1'b0;
            res.done = 1'b0;
            step_q.push_back(res);
        endfunction

        // Emit the held whites, as black when the gap is filled
        function void flush_whites(bit fill);
            for (int k = 0; k < held_n; k++) begin
                emit_px(fill ? C_PIX_BLACK : held_px[k]);
            end
            held_n = 0;
        endfunction

        function void clear_line();
            held_n     = 0;
            black_seen = 0;
            gap_open   = 0;
        endfunction

        function void note_pixel(logic [C_PIX_W-1:0] p, logic le);
            int unsigned r;
            r = (range_reg > C_MAX_RANGE) ? C_MAX_RANGE : range_reg;
            step_q.delete();
            if (!enable_reg) begin
                flush_whites(1'b0);
                emit_px(p);
                clear_line();
            end else begin
                if (!black_seen) begin
                    if (p != C_PIX_BLACK) begin
                        emit_px(C_PIX_WHITE);
                    end else begin
                        black_seen = 1'b1;
                        emit_px(C_PIX_BLACK);
                    end
                end else if (p == C_PIX_BLACK) begin
                    flush_whites(held_n < r);
                    gap_open = 1'b0;
                    emit_px(C_PIX_BLACK);
                end else if (gap_open) begin
                    emit_px(p);
                end else if (held_n + 1 >= r) begin
                    // Gap already too long to fill: let it pass unchanged
                    flush_whites(1'b0);
                    emit_px(p);
                    gap_open = 1'b1;
                end else begin
                    held_px[held_n] = p;
                    held_n++;
                end
                if (le) begin
                    flush_whites(1'b0);
                    clear_line();
                end
            end
            if (step_q.size() > 0) begin
                step_q[step_q.size()-1].last = 1'b1;
                step_q[step_q.size()-1].done = le;
            end
            foreach (step_q[k]) pending_pixels.push_back(step_q[k]);
        endfunction

        function void check_pixel(logic [C_PIX_W-1:0] px, logic last, logic done);
            smear_result_t want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: expected no result, actual pixel %0d last %b done %b",
                         $time, px, last, done);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (px !== want.px) begin
                $display("%0t: pixel_out expected %0d actual %0d", $time, want.px, px);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: last_of_run expected %b actual %b", $time, want.last, last);
                errors++;
            end
            if (done !== want.done) begin
                $display("%0t: line_done expected %b actual %b", $time, want.done, done);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   cfg_we     = 1'b0;
    logic [C_CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [C_RANGE_W-1:0]   cfg_data   = '0;
    logic                   in_valid   = 1'b0;
    logic [C_PIX_W-1:0]     pixel_in   = '0;
    logic                   line_end   = 1'b0;
    logic                   out_stall  = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic [C_PIX_W-1:0]     o_pixel_out;
    logic                   o_last_of_run;
    logic                   o_line_done;

    smear_checker sb = new();

    bit          calm      = 1'b0;
    bit          hold_req  = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;
    int          idle_run  = 0;
    int unsigned cur_range = 0;

    run_length_smear_line_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_pixel_in    (pixel_in),
        .i_line_end    (line_end),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_out   (o_pixel_out),
        .o_last_of_run (o_last_of_run),
        .o_line_done   (o_line_done)
    );

    // Clock: 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: random stall, one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !calm && ($urandom_range(0, 99) < 25);
        end
    end

    // Monitor both channels and watch for a hung block
    always @(posedge i_clk) begin
        bit took;
        took = 1'b0;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                sb.note_pixel(pixel_in, line_end);
                took = 1'b1;
            end
            if (o_out_valid === 1'b1 && !out_stall) begin
                sb.check_pixel(o_pixel_out, o_last_of_run, o_line_done);
                took = 1'b1;
            end
        end
        if (!i_rst_n || took) idle_run = 0;
        else idle_run++;
        if (idle_run >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offer one pixel request, idling first at random, and wait until it is taken
    task automatic send_pixel(input logic [C_PIX_W-1:0] px, input logic le);
        int gap;
        if (!calm && $urandom_range(0, 99) < 25) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        line_end <= le;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_reg(input logic [C_CFG_IDX_W-1:0] idx,
                             input logic [C_RANGE_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
        if (idx == C_REG_SMEAR_RANGE) cur_range = val;
        @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted pixel has come out
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    function automatic int unsigned gap_len(int unsigned r);
        case ($urandom_range(0, 5))
            0:       return (r > 2) ? $urandom_range(1, r - 2) : 1;
            1:       return (r > 0) ? r - 1 : 0;
            2:       return r;
            3:       return r + 1;
            4:       return $urandom_range(0, 3);
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    // Send one line: mostly black runs and white gaps near the range, some noise
    task automatic send_line();
        logic [C_PIX_W-1:0] line_px[$];
        int unsigned        r;
        int unsigned        n;
        int unsigned        segs;
        bit                 closed;
        r = (cur_range > C_MAX_RANGE) ? C_MAX_RANGE : cur_range;
        if ($urandom_range(0, 99) < 15) begin
            n = $urandom_range(1, 12);
            repeat (n) begin
                if ($urandom_range(0, 99) < 40) line_px.push_back(C_PIX_BLACK);
                else line_px.push_back(C_PIX_W'($urandom_range(1, 255)));
            end
            closed = 1'($urandom_range(0, 1));
        end else begin
            repeat ($urandom_range(0, 2)) line_px.push_back(C_PIX_W'($urandom_range(1, 255)));
            segs = (r > 16) ? 1 : $urandom_range(1, 3);
            repeat (segs) begin
                repeat ($urandom_range(1, 2)) line_px.push_back(C_PIX_BLACK);
                n = gap_len(r);
                repeat (n) line_px.push_back(C_PIX_W'($urandom_range(1, 255)));
            end
            if ($urandom_range(0, 1)) line_px.push_back(C_PIX_BLACK);
            closed = 1'b1;
        end
        foreach (line_px[k]) begin
            send_pixel(line_px[k], closed && (k == line_px.size() - 1));
        end
    endtask

    initial begin
        int unsigned ph_range [10] = '{127, 64, 1, 3, 8, 30, 2, 63, 5, 0};
        bit          ph_en    [10] = '{1, 1, 1, 1, 1, 0, 1, 1, 1, 1};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings, range 0: a leading white, gap opens at once, line end;
        // hold the receiver off so every pixel backs up and the input stalls
        hold_req = 1'b1;
        send_pixel(8'd7, 1'b0);
        send_pixel(C_PIX_BLACK, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(C_PIX_BLACK, 1'b0);
        send_pixel(8'd85, 1'b1);
        send_pixel(C_PIX_BLACK, 1'b1);
        settle();

        // Full range: filled gap, then whites still held at the line end
        write_reg(C_REG_SMEAR_RANGE, 7'd64);
        send_pixel(C_PIX_BLACK, 1'b0);
        send_pixel(8'd1, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd170, 1'b0);
        send_pixel(C_PIX_BLACK, 1'b0);
        send_pixel(8'd9, 1'b0);
        send_pixel(8'd10, 1'b1);

        // Change the range while a gap is held
        send_pixel(C_PIX_BLACK, 1'b0);
        send_pixel(8'd40, 1'b0);
        send_pixel(8'd41, 1'b0);
        settle();
        write_reg(C_REG_SMEAR_RANGE, 7'd2);
        write_reg(REG_SPARE_A, 7'h7F);
        send_pixel(C_PIX_BLACK, 1'b0);
        send_pixel(8'd66, 1'b0);
        send_pixel(C_PIX_BLACK, 1'b1);

        // Disable with a white still held
        send_pixel(C_PIX_BLACK, 1'b0);
        send_pixel(8'd99, 1'b0);
        settle();
        write_reg(C_REG_SMEAR_ENABLE, 7'h7E);
        write_reg(REG_SPARE_B, 7'h55);
        send_pixel(8'd50, 1'b0);
        send_pixel(C_PIX_BLACK, 1'b1);
        settle();

        // Random lines under a series of settings, no idling in the middle phases
        foreach (ph_range[p]) begin
            write_reg(C_REG_SMEAR_RANGE, C_RANGE_W'(ph_range[p]));
            write_reg(C_REG_SMEAR_ENABLE, {6'($urandom), ph_en[p]});
            if (p == 3) write_reg(REG_SPARE_A, 7'($urandom));
            if (p == 7) write_reg(REG_SPARE_B, 7'($urandom));
            calm = (p >= 4 && p <= 6);
            send_line();
            settle();
        end

        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### files.f
rtl/core/rlsl_pkg.sv
rtl/core/rlsl_front.sv
rtl/core/rlsl_cmd_fifo.sv
rtl/core/rlsl_back.sv
rtl/core/run_length_smear_line_core.sv
rtl/core/rlsl_checker.sv
tb/testbench.sv
